// ===== src/tqle_pkg.sv =====
// shared types, constants and helpers of the tabular q-learning engine
`default_nettype none

package tqle_pkg;

	localparam int NUM_STATES_DEF  = 32;
	localparam int NUM_ACTIONS_DEF = 4;

	localparam logic [16:0] LEARNING_RATE_RESET = 17'd32768;
	localparam logic [16:0] DISCOUNT_RESET      = 17'd58982;
	localparam logic [16:0] EXPLORE_RATE_RESET  = 17'd45875;

	localparam logic signed [17:0] Q_ONE = 18'sd65536;

	typedef enum logic {
		OP_SELECT = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_LEARNING_RATE = 2'd0,
		REG_DISCOUNT      = 2'd1,
		REG_EXPLORE_RATE  = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		op_t                operation;
		logic [4:0]         state_index;
		logic [1:0]         action_taken;
		logic signed [15:0] reward;
		logic [4:0]         next_state_index;
		logic [16:0]        random_fraction;
		logic [1:0]         random_action;
		logic [16:0]        episode_progress;
	} query_t;

	typedef struct packed {
		logic [1:0]         chosen_action;
		logic               explored;
		logic signed [31:0] q_value;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic mul1_en;
		logic tgt_en;
		logic mul2_en;
	} arith_ctl_t;

	typedef struct packed {
		logic signed [31:0] new_value;
		logic               saturated;
	} upd_res_t;

	// small index reduced modulo n by restoring subtraction, five narrow steps
	function automatic logic [4:0] mod_small(input logic [4:0] v, input int unsigned n);
		logic [21:0] r;
		logic [21:0] d;
		r = {17'd0, v};
		for (int k = 4; k >= 0; k--) begin
			d = 22'(n) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[4:0];
	endfunction

endpackage

`default_nettype wire

// ===== src/tqle_ram.sv =====
// single-port-write, single-port-read q table memory with registered read data
`default_nettype none

module tqle_ram #(
	parameter int DEPTH = tqle_pkg::NUM_STATES_DEF * tqle_pkg::NUM_ACTIONS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [AW-1:0]         wr_addr,
	input  wire logic signed [31:0]    wr_data,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	output      logic signed [31:0]    rd_data
);

	logic signed [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/tqle_arith.sv =====
// staged fixed-point q update: target, blend and saturation
`default_nettype none

module tqle_arith (
	input  wire logic                 clk,
	input  wire tqle_pkg::arith_ctl_t ctl,
	input  wire logic [16:0]          learning_rate,
	input  wire logic [16:0]          discount,
	input  wire logic signed [15:0]   reward,
	input  wire logic signed [31:0]   next_max,
	input  wire logic signed [31:0]   old_value,
	output      tqle_pkg::upd_res_t   res
);

	localparam logic signed [36:0] SAT_HI = 37'sh0_7FFF_FFFF;
	localparam logic signed [36:0] SAT_LO = ~SAT_HI;

	logic signed [17:0] disc_s;
	logic signed [17:0] rate_s;
	logic signed [17:0] keep_s;
	logic signed [49:0] p1_s1;
	logic signed [49:0] p2_s1;
	logic signed [33:0] tgt_s2;
	logic signed [51:0] p3_s3;
	logic signed [33:0] reward_w;
	logic signed [33:0] disc_term;
	logic signed [52:0] acc;
	logic signed [36:0] nv;

	assign disc_s = $signed({1'b0, discount});
	assign rate_s = $signed({1'b0, learning_rate});
	// one minus rate, may go negative for rates above one
	assign keep_s = tqle_pkg::Q_ONE - rate_s;

	assign reward_w  = $signed({{2{reward[15]}}, reward, 16'd0});
	// arithmetic shift keeps the floor toward minus infinity
	assign disc_term = $signed(p1_s1[49:16]);

	always_ff @(posedge clk) begin
		if (ctl.mul1_en) begin
			p1_s1 <= disc_s * next_max;
			p2_s1 <= keep_s * old_value;
		end
		if (ctl.tgt_en) begin
			tgt_s2 <= reward_w + disc_term;
		end
		if (ctl.mul2_en) begin
			p3_s3 <= rate_s * tgt_s2;
		end
	end

	assign acc = p2_s1 + p3_s3;
	assign nv  = $signed(acc[52:16]);

	always_comb begin
		if (nv > SAT_HI) begin
			res.new_value = SAT_HI[31:0];
			res.saturated = 1'b1;
		end else if (nv < SAT_LO) begin
			res.new_value = SAT_LO[31:0];
			res.saturated = 1'b1;
		end else begin
			res.new_value = nv[31:0];
			res.saturated = 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== src/tabular_q_learning_engine.sv =====
// Tabular Q-learning engine: Q table in one synchronous memory, epsilon-greedy select and
// saturating Q16.16 update. After reset a clearing pass writes zero to every entry, one a
// cycle, during which no item is taken. One item is worked at a time and the row scan through
// the single memory read port sets the pace: a select reads its row and finishes, an update
// also reads the old entry, then passes three multiply and add stages. A new item is taken in
// the cycle after the result is loaded into the output register, even while that result waits
// to be taken.
`default_nettype none

module tabular_q_learning_engine #(
	parameter int NUM_STATES  = tqle_pkg::NUM_STATES_DEF,
	parameter int NUM_ACTIONS = tqle_pkg::NUM_ACTIONS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	output      logic             cmd_stall,
	input  wire tqle_pkg::query_t cmd,
	output      logic             rsp_valid,
	input  wire logic             rsp_stall,
	output      tqle_pkg::result_t rsp,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [16:0]      cfg_data
);

	localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $clog2(NUM_STATES);
	localparam int ACW   = $clog2(NUM_ACTIONS);
	localparam int CW    = $clog2(NUM_ACTIONS + 1);
	localparam logic [AW-1:0] NA_A     = AW'(NUM_ACTIONS);
	localparam logic [AW-1:0] LAST_ENT = AW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_OLD  = CW'(NUM_ACTIONS);
	localparam logic [CW-1:0] CNT_LAST = CW'(NUM_ACTIONS - 1);

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_READ  = 8'b0000_0100,
		ST_LAST  = 8'b0000_1000,
		ST_MUL1  = 8'b0001_0000,
		ST_TGT   = 8'b0010_0000,
		ST_MUL2  = 8'b0100_0000,
		ST_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [16:0] lr_q;
	logic [16:0] disc_q;
	logic [16:0] expl_q;

	logic [AW-1:0] clr_q;
	logic [CW-1:0] cnt_q;

	tqle_pkg::op_t      op_q;
	logic [AW-1:0]      base_q;
	logic [AW-1:0]      upd_addr_q;
	logic [ACW-1:0]     act_q;
	logic               thr_hit_q;
	logic signed [15:0] reward_q;

	logic               tag_vld_s1;
	logic               tag_old_s1;
	logic [ACW-1:0]     tag_idx_s1;
	logic signed [31:0] max_q;
	logic [ACW-1:0]     arg_q;
	logic signed [31:0] old_q;

	logic              rsp_valid_q;
	tqle_pkg::result_t rsp_q;

	logic               accept;
	logic               last_rd;
	logic               slot_free;
	logic               fin_go;
	logic [SW-1:0]      s_red;
	logic [SW-1:0]      ns_red;
	logic [ACW-1:0]     a_red;
	logic [ACW-1:0]     ra_red;
	logic signed [17:0] thr;
	logic               explore;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_data;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic signed [31:0] wr_data;

	tqle_pkg::arith_ctl_t ctl;
	tqle_pkg::upd_res_t   upd;

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept    = cmd_valid && !cmd_stall;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign fin_go    = (state_q == ST_FIN) && slot_free;
	assign last_rd   = (op_q == tqle_pkg::OP_UPDATE) ? (cnt_q == CNT_OLD) : (cnt_q == CNT_LAST);

	assign s_red  = SW'(tqle_pkg::mod_small(cmd.state_index, NUM_STATES));
	assign ns_red = SW'(tqle_pkg::mod_small(cmd.next_state_index, NUM_STATES));
	assign a_red  = ACW'(tqle_pkg::mod_small({3'd0, cmd.action_taken}, NUM_ACTIONS));
	assign ra_red = ACW'(tqle_pkg::mod_small({3'd0, cmd.random_action}, NUM_ACTIONS));
	assign thr    = $signed({1'b0, expl_q}) - $signed({1'b0, cmd.episode_progress});

	assign explore = (max_q == 32'sd0) || thr_hit_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= tqle_pkg::LEARNING_RATE_RESET;
			disc_q <= tqle_pkg::DISCOUNT_RESET;
			expl_q <= tqle_pkg::EXPLORE_RATE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tqle_pkg::REG_LEARNING_RATE: lr_q   <= cfg_data;
				tqle_pkg::REG_DISCOUNT:      disc_q <= cfg_data;
				tqle_pkg::REG_EXPLORE_RATE:  expl_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			cnt_q      <= '0;
			tag_vld_s1 <= 1'b0;
		end else begin
			tag_vld_s1 <= (state_q == ST_READ);
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST_ENT) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + CW'(1);
					if (last_rd) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= (op_q == tqle_pkg::OP_UPDATE) ? ST_MUL1 : ST_FIN;
				end
				ST_MUL1: state_q <= ST_TGT;
				ST_TGT:  state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_FIN;
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item fields held for the duration of the item
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= cmd.operation;
			base_q     <= AW'(AW'((cmd.operation == tqle_pkg::OP_UPDATE) ? ns_red : s_red) * NA_A);
			upd_addr_q <= AW'(AW'(s_red) * NA_A) + AW'(a_red);
			act_q      <= (cmd.operation == tqle_pkg::OP_UPDATE) ? a_red : ra_red;
			thr_hit_q  <= ($signed({1'b0, cmd.random_fraction}) <= thr);
			reward_q   <= cmd.reward;
		end
		if (state_q == ST_READ) begin
			tag_old_s1 <= (cnt_q == CNT_OLD);
			tag_idx_s1 <= cnt_q[ACW-1:0];
		end
		// row maximum, first index wins on ties
		if (tag_vld_s1) begin
			if (tag_old_s1) begin
				old_q <= rd_data;
			end else if ((tag_idx_s1 == '0) || (rd_data > max_q)) begin
				max_q <= rd_data;
				arg_q <= tag_idx_s1;
			end
		end
	end

	assign rd_en   = (state_q == ST_READ);
	assign rd_addr = (cnt_q == CNT_OLD) ? upd_addr_q : (base_q + AW'(cnt_q));

	assign wr_en   = (state_q == ST_CLEAR) || (fin_go && (op_q == tqle_pkg::OP_UPDATE));
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : upd_addr_q;
	assign wr_data = (state_q == ST_CLEAR) ? 32'sd0 : upd.new_value;

	tqle_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign ctl.mul1_en = (state_q == ST_MUL1);
	assign ctl.tgt_en  = (state_q == ST_TGT);
	assign ctl.mul2_en = (state_q == ST_MUL2);

	tqle_arith u_arith (
		.clk           (clk),
		.ctl           (ctl),
		.learning_rate (lr_q),
		.discount      (disc_q),
		.reward        (reward_q),
		.next_max      (max_q),
		.old_value     (old_q),
		.res           (upd)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin_go) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			if (op_q == tqle_pkg::OP_UPDATE) begin
				rsp_q.chosen_action <= 2'(act_q);
				rsp_q.explored      <= 1'b0;
				rsp_q.q_value       <= upd.new_value;
				rsp_q.saturated     <= upd.saturated;
			end else begin
				rsp_q.chosen_action <= explore ? 2'(act_q) : 2'(arg_q);
				rsp_q.explored      <= explore;
				rsp_q.q_value       <= max_q;
				rsp_q.saturated     <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("q table read and write in the same cycle");

	// a result appears only out of the finishing step
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result raised outside the finishing step");

	// the clearing pass runs once after reset
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |=> (state_q != ST_CLEAR))
		else $error("clearing pass re-entered");

	// exploration and clipping belong to different item kinds
	a_sat_not_explored: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.saturated) |-> !rsp_q.explored)
		else $error("result both explored and saturated");

	// scan tags arrive in the cycle after their read
	a_tag_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |=> tag_vld_s1)
		else $error("read data lost its tag");

endmodule

`default_nettype wire

// ===== dv/tabular_q_learning_engine_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the tabular q-learning engine: scoreboarded selects and updates
module tabular_q_learning_engine_tb;
	import tqle_pkg::*;

	localparam int ROWS = NUM_STATES_DEF;
	localparam int COLS = NUM_ACTIONS_DEF;
	localparam logic [1:0] CFG_INDEX_SPARE = 2'd3;
	localparam longint Q_HIGH = 64'sd2147483647;
	localparam longint Q_LOW = -64'sd2147483648;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	query_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	result_t rsp;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [16:0] cfg_data;

	// mirror of the q table and the three rate registers
	logic signed [31:0] q_model [ROWS*COLS];
	logic [16:0] rate_q;
	logic [16:0] gamma_q;
	logic [16:0] epsilon_q;

	result_t q_answers_due [$];
	int fail_count;
	bit tx_gaps_on;
	bit rx_stalls_on;
	int rx_hold_req;
	int cycle_count;

	tabular_q_learning_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void row_peak(input int row, output logic signed [31:0] peak,
			output logic [1:0] peak_act);
		peak = q_model[row*COLS];
		peak_act = '0;
		// strict compare keeps the first action on a tie
		for (int a = 1; a < COLS; a++) begin
			if (q_model[row*COLS + a] > peak) begin
				peak = q_model[row*COLS + a];
				peak_act = 2'(a);
			end
		end
	endfunction

	function automatic void learn_step(input query_t q);
		result_t r;
		logic signed [31:0] peak;
		logic [1:0] peak_act;
		int s;
		int a;
		int ns;
		int slot;
		longint old_v;
		longint tgt;
		longint acc;
		longint nv;
		longint th;
		s = int'(q.state_index) % ROWS;
		a = int'(q.action_taken) % COLS;
		ns = int'(q.next_state_index) % ROWS;
		r = '0;
		if (q.operation == OP_SELECT) begin
			row_peak(s, peak, peak_act);
			th = longint'(epsilon_q) - longint'(q.episode_progress);
			r.q_value = peak;
			if (peak == 0 || longint'(q.random_fraction) <= th) begin
				r.chosen_action = 2'(int'(q.random_action) % COLS);
				r.explored = 1'b1;
			end else begin
				r.chosen_action = peak_act;
			end
		end else begin
			slot = s*COLS + a;
			old_v = q_model[slot];
			// next row is read before the write, so s' == s sees the old entry
			row_peak(ns, peak, peak_act);
			tgt = longint'($signed(q.reward)) * 65536
				+ ((longint'(gamma_q) * longint'(peak)) >>> 16);
			acc = (65536 - longint'(rate_q)) * old_v + longint'(rate_q) * tgt;
			nv = acc >>> 16;
			if (nv > Q_HIGH) begin
				nv = Q_HIGH;
				r.saturated = 1'b1;
			end else if (nv < Q_LOW) begin
				nv = Q_LOW;
				r.saturated = 1'b1;
			end
			q_model[slot] = 32'(nv);
			r.chosen_action = 2'(a);
			r.q_value = 32'(nv);
		end
		q_answers_due.push_back(r);
	endfunction

	function automatic query_t mk_query(input op_t op, input logic [4:0] s,
			input logic [1:0] a, input logic signed [15:0] rew, input logic [4:0] ns,
			input logic [16:0] rf, input logic [1:0] ra, input logic [16:0] prog);
		query_t q;
		q.operation = op;
		q.state_index = s;
		q.action_taken = a;
		q.reward = rew;
		q.next_state_index = ns;
		q.random_fraction = rf;
		q.random_action = ra;
		q.episode_progress = prog;
		return q;
	endfunction

	function automatic query_t rand_query();
		query_t q;
		longint th;
		int pick;
		q = '0;
		q.operation = $urandom_range(0, 1) ? OP_UPDATE : OP_SELECT;
		// a few hot rows so updates and selects keep meeting each other
		q.state_index = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 3)) : 5'($urandom);
		q.next_state_index = ($urandom_range(0, 9) < 6) ? 5'($urandom_range(0, 3))
			: 5'($urandom);
		q.action_taken = 2'($urandom);
		q.random_action = 2'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			q.reward = 16'(int'($urandom_range(0, 200)) - 100);
		end else if (pick < 9) begin
			q.reward = 16'($urandom);
		end else begin
			q.reward = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		end
		q.episode_progress = $urandom_range(0, 1) ? 17'($urandom_range(0, 65536))
			: 17'($urandom);
		th = longint'(epsilon_q) - longint'(q.episode_progress);
		if ($urandom_range(0, 2) == 0 && th >= 1 && th < 131071) begin
			q.random_fraction = 17'(th + longint'($urandom_range(0, 2)) - 1);
		end else begin
			q.random_fraction = 17'($urandom);
		end
		return q;
	endfunction

	task automatic send_query(input query_t q);
		int gap;
		gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
		repeat (gap) @(negedge clk);
		cmd = q;
		cmd_valid = 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		learn_step(q);
		@(negedge clk);
		cmd_valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (q_answers_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_LEARNING_RATE: rate_q = val;
			REG_DISCOUNT: gamma_q = val;
			REG_EXPLORE_RATE: epsilon_q = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [16:0] lr, input logic [16:0] g,
			input logic [16:0] eps);
		write_reg(REG_LEARNING_RATE, lr);
		write_reg(REG_DISCOUNT, g);
		write_reg(REG_EXPLORE_RATE, eps);
	endtask

	// untouched table: every select explores
	task automatic test_cold_table();
		send_query(mk_query(OP_SELECT, 5'd0, 2'd0, 16'sd0, 5'd0, 17'h1FFFF, 2'd3, 17'd0));
		send_query(mk_query(OP_SELECT, 5'd31, 2'd3, 16'sh7FFF, 5'd31, 17'd0, 2'd0,
			17'h1FFFF));
	endtask

	task automatic test_update_edges();
		send_query(mk_query(OP_UPDATE, 5'd5, 2'd3, 16'sh7FFF, 5'd5, 17'h1FFFF, 2'd1,
			17'h1FFFF));
		send_query(mk_query(OP_UPDATE, 5'd5, 2'd0, 16'sh8000, 5'd5, 17'd0, 2'd2, 17'd0));
		send_query(mk_query(OP_UPDATE, 5'd31, 2'd2, 16'sd1, 5'd0, 17'd0, 2'd0, 17'd0));
		send_query(mk_query(OP_UPDATE, 5'd0, 2'd1, 16'sd100, 5'd31, 17'd0, 2'd0, 17'd0));
		send_query(mk_query(OP_SELECT, 5'd5, 2'd1, 16'sh7FFF, 5'd9, 17'd0, 2'd2, 17'd0));
		send_query(mk_query(OP_SELECT, 5'd5, 2'd1, 16'sh8000, 5'd9, 17'h1FFFF, 2'd2, 17'd0));
	endtask

	// fraction right on, and just past, epsilon minus progress
	task automatic test_threshold_edges();
		send_query(mk_query(OP_SELECT, 5'd31, 2'd0, 16'sd0, 5'd0, epsilon_q, 2'd1, 17'd0));
		send_query(mk_query(OP_SELECT, 5'd31, 2'd0, 16'sd0, 5'd0, epsilon_q + 17'd1, 2'd1,
			17'd0));
		send_query(mk_query(OP_SELECT, 5'd31, 2'd0, 16'sd0, 5'd0, 17'd0, 2'd1, 17'd65536));
	endtask

	task automatic test_ties_and_negatives();
		send_query(mk_query(OP_UPDATE, 5'd10, 2'd1, 16'sd50, 5'd20, 17'd0, 2'd0, 17'd0));
		send_query(mk_query(OP_UPDATE, 5'd10, 2'd3, 16'sd50, 5'd20, 17'd0, 2'd0, 17'd0));
		send_query(mk_query(OP_SELECT, 5'd10, 2'd0, 16'sd0, 5'd0, 17'h1FFFF, 2'd2, 17'd0));
		for (int a = 0; a < COLS; a++) begin
			send_query(mk_query(OP_UPDATE, 5'd12, 2'(a), 16'(-1 - a), 5'd12, 17'd0, 2'd0,
				17'd0));
		end
		send_query(mk_query(OP_SELECT, 5'd12, 2'd0, 16'sd0, 5'd0, 17'h1FFFF, 2'd3, 17'd0));
	endtask

	// rates above one drive the entry past both ends of the range
	task automatic test_saturation();
		wait_idle();
		apply_settings(17'h1FFFF, 17'h1FFFF, epsilon_q);
		send_query(mk_query(OP_UPDATE, 5'd20, 2'd0, 16'sh7FFF, 5'd20, 17'd0, 2'd0, 17'd0));
		send_query(mk_query(OP_UPDATE, 5'd20, 2'd1, 16'sh8000, 5'd21, 17'd0, 2'd0, 17'd0));
		wait_idle();
		write_reg(CFG_INDEX_SPARE, 17'd0);
		send_query(mk_query(OP_UPDATE, 5'd20, 2'd0, 16'sd0, 5'd20, 17'd0, 2'd0, 17'd0));
	endtask

	// receiver holds off for a long stretch so the engine backs up into its input
	task automatic test_backpressure();
		wait_idle();
		apply_settings(LEARNING_RATE_RESET, DISCOUNT_RESET, EXPLORE_RATE_RESET);
		tx_gaps_on = 1'b0;
		rx_hold_req = 400;
		repeat (30) send_query(rand_query());
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_phase(input logic [16:0] lr, input logic [16:0] g,
			input logic [16:0] eps, input int n, input bit gaps, input bit stalls);
		wait_idle();
		apply_settings(lr, g, eps);
		tx_gaps_on = gaps;
		rx_stalls_on = stalls;
		repeat (n) send_query(rand_query());
	endtask

	initial begin : reply_side
		int stall_left;
		int hold_left;
		result_t want;
		stall_left = 0;
		hold_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
				if (q_answers_due.size() == 0) begin
					$error("unexpected item: q_value %0d", rsp.q_value);
					fail_count++;
				end else begin
					want = q_answers_due.pop_front();
					if (rsp.chosen_action !== want.chosen_action) begin
						$error("chosen_action: expected %0d, got %0d",
							want.chosen_action, rsp.chosen_action);
						fail_count++;
					end
					if (rsp.explored !== want.explored) begin
						$error("explored: expected %0d, got %0d", want.explored,
							rsp.explored);
						fail_count++;
					end
					if (rsp.q_value !== want.q_value) begin
						$error("q_value: expected %0d, got %0d", want.q_value,
							rsp.q_value);
						fail_count++;
					end
					if (rsp.saturated !== want.saturated) begin
						$error("saturated: expected %0d, got %0d", want.saturated,
							rsp.saturated);
						fail_count++;
					end
				end
				stall_left = rx_stalls_on ? $urandom_range(0, 3) : 0;
			end
			@(negedge clk);
			if (rx_hold_req > 0) begin
				hold_left = rx_hold_req;
				rx_hold_req = 0;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				rsp_stall = 1'b1;
				if (rsp_valid === 1'b1) begin
					stall_left--;
				end
			end else begin
				rsp_stall = 1'b0;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[tabular_q_learning_engine] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = REG_LEARNING_RATE;
		cfg_data = '0;
		tx_gaps_on = 1'b1;
		rx_stalls_on = 1'b1;
		rx_hold_req = 0;
		fail_count = 0;
		rate_q = LEARNING_RATE_RESET;
		gamma_q = DISCOUNT_RESET;
		epsilon_q = EXPLORE_RATE_RESET;
		foreach (q_model[i]) q_model[i] = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_cold_table();
		test_update_edges();
		test_threshold_edges();
		test_ties_and_negatives();
		test_saturation();
		test_backpressure();
		test_random_phase(LEARNING_RATE_RESET, DISCOUNT_RESET, EXPLORE_RATE_RESET, 200, 1, 1);
		test_random_phase(17'd65536, 17'd65536, 17'd0, 200, 0, 0);
		test_random_phase(17'd0, 17'd0, 17'd65536, 150, 1, 1);
		test_random_phase(17'd1, 17'd32768, 17'd20000, 200, 1, 0);
		test_random_phase(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 150, 0, 1);
		test_random_phase(17'($urandom), 17'($urandom), 17'($urandom), 250, 1, 1);
		wait_idle();

		if (fail_count == 0) begin
			$display("[tabular_q_learning_engine] OK");
		end else begin
			$display("[tabular_q_learning_engine] ERROR");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tqle_pkg.sv
src/tqle_ram.sv
src/tqle_arith.sv
src/tabular_q_learning_engine.sv
dv/tabular_q_learning_engine_tb.sv
